@@ design/asmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ambiguity set median cost: shared types, constants and microcode
// Field widths, sequencer control word, status word and the control ROM.
// ----------------------------------------------------------------------------
package asmc_pkg;

	localparam int ALPHABET_SIZE_DEF = 5;
	localparam int COST_WIDTH_DEF    = 16;

	localparam int SYM_W   = 3;
	localparam int SET_W   = 8;
	localparam int ENTRY_W = 16;
	localparam int SUM_W   = 18;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [2:0] {
		STEP_FETCH,
		STEP_LOOP,
		STEP_DRAIN,
		STEP_DONE,
		STEP_ERR
	} step_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_ACCEPT,
		JMP_LAST,
		JMP_OUT
	} jmp_t;

	typedef struct packed {
		logic  accept;
		logic  min_en;
		logic  cnt_inc;
		logic  cnt_clr;
		logic  out_ld;
		logic  out_err;
		jmp_t  jmp;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic acc;
		logic write;
		logic empty;
		logic last;
		logic out_free;
	} stat_t;

	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '0;
		w.jmp = JMP_NEXT;
		w.target = STEP_FETCH;
		case (step)
			STEP_FETCH: begin
				w.accept = 1'b1;
				w.jmp = JMP_ACCEPT;
				w.target = STEP_LOOP;
			end
			STEP_LOOP: begin
				w.min_en = 1'b1;
				w.cnt_inc = 1'b1;
				w.jmp = JMP_LAST;
				w.target = STEP_DRAIN;
			end
			STEP_DRAIN: begin
				w.jmp = JMP_NEXT;
				w.target = STEP_DONE;
			end
			STEP_DONE: begin
				w.out_ld = 1'b1;
				w.cnt_clr = 1'b1;
				w.jmp = JMP_OUT;
				w.target = STEP_FETCH;
			end
			STEP_ERR: begin
				w.out_ld = 1'b1;
				w.out_err = 1'b1;
				w.jmp = JMP_OUT;
				w.target = STEP_FETCH;
			end
			default: begin
				w.jmp = JMP_NEXT;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ design/asmc_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ambiguity set median cost: microcode sequencer
// Step counter with conditional jumps; control word read from the ROM.
// ----------------------------------------------------------------------------
module asmc_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire asmc_pkg::stat_t stat,
	output asmc_pkg::ctl_t       ctl
);

	asmc_pkg::step_t step_q;
	asmc_pkg::step_t step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= asmc_pkg::STEP_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl = asmc_pkg::ucode(step_q);
		step_d = step_q;
		case (ctl.jmp)
			asmc_pkg::JMP_NEXT: begin
				step_d = ctl.target;
			end
			asmc_pkg::JMP_ACCEPT: begin
				if (stat.acc) begin
					if (stat.write) begin
						step_d = asmc_pkg::STEP_FETCH;
					end else if (stat.empty) begin
						step_d = asmc_pkg::STEP_ERR;
					end else begin
						step_d = ctl.target;
					end
				end
			end
			asmc_pkg::JMP_LAST: begin
				if (stat.last) begin
					step_d = ctl.target;
				end
			end
			asmc_pkg::JMP_OUT: begin
				if (stat.out_free) begin
					step_d = ctl.target;
				end
			end
			default: begin
				step_d = asmc_pkg::STEP_FETCH;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/asmc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ambiguity set median cost: datapath
// Column-organized cost table, masked set minimums and running best sum.
// ----------------------------------------------------------------------------
module asmc_dp #(
	parameter int ALPHABET_SIZE = asmc_pkg::ALPHABET_SIZE_DEF,
	parameter int COST_WIDTH    = asmc_pkg::COST_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire asmc_pkg::ctl_t                ctl,
	input  wire logic                          acc,
	input  wire logic                          func,
	input  wire logic [asmc_pkg::SYM_W-1:0]    row_symbol,
	input  wire logic [asmc_pkg::SYM_W-1:0]    col_symbol,
	input  wire logic [asmc_pkg::ENTRY_W-1:0]  entry_cost,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_first,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_second,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_third,
	input  wire logic                          three_way,
	output logic                               last,
	output logic [asmc_pkg::SUM_W-1:0]         best,
	output logic [asmc_pkg::SET_W-1:0]         median
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int ACC_W = (COST_WIDTH + 2 > asmc_pkg::SUM_W) ? COST_WIDTH + 2
		: asmc_pkg::SUM_W;
	localparam logic [asmc_pkg::SYM_W:0] SYM_LIM = (asmc_pkg::SYM_W+1)'(ALPHABET_SIZE);
	localparam logic [IDX_W:0]           IDX_LIM = (IDX_W+1)'(ALPHABET_SIZE);
	localparam logic [IDX_W-1:0]         IDX_LAST = IDX_W'(ALPHABET_SIZE - 1);

	typedef logic [ALPHABET_SIZE-1:0][COST_WIDTH-1:0] col_t;

	col_t mem [ALPHABET_SIZE];
	col_t col_q;

	logic                     wr_en;
	logic [IDX_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         cnt_d;
	logic [ALPHABET_SIZE-1:0] set_a_q;
	logic [ALPHABET_SIZE-1:0] set_b_q;
	logic [ALPHABET_SIZE-1:0] set_c_q;
	logic                     three_q;
	logic [COST_WIDTH-1:0]    min_a;
	logic [COST_WIDTH-1:0]    min_b;
	logic [COST_WIDTH-1:0]    min_c;
	logic [COST_WIDTH-1:0]    min_a_s1;
	logic [COST_WIDTH-1:0]    min_b_s1;
	logic [COST_WIDTH-1:0]    min_c_s1;
	logic [IDX_W-1:0]         cand_s1;
	logic                     vld_s1;
	logic [ACC_W-1:0]         sum;
	logic [asmc_pkg::SUM_W-1:0] sat;
	logic [asmc_pkg::SET_W-1:0] cand_bit;
	logic [asmc_pkg::SUM_W-1:0] best_q;
	logic [asmc_pkg::SET_W-1:0] median_q;

	assign wr_en = acc && !func && ({1'b0, row_symbol} < SYM_LIM)
		&& ({1'b0, col_symbol} < SYM_LIM);

	always_comb begin
		if (ctl.cnt_clr) begin
			cnt_d = '0;
		end else if (ctl.cnt_inc) begin
			cnt_d = cnt_q + 1'b1;
		end else begin
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	assign last = (cnt_q == IDX_LAST);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[col_symbol[IDX_W-1:0]][row_symbol[IDX_W-1:0]] <= COST_WIDTH'(entry_cost);
		end
		if ({1'b0, cnt_d} < IDX_LIM) begin
			col_q <= mem[cnt_d];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			set_a_q <= amb_first[ALPHABET_SIZE-1:0];
			set_b_q <= amb_second[ALPHABET_SIZE-1:0];
			set_c_q <= amb_third[ALPHABET_SIZE-1:0];
			three_q <= three_way;
		end
	end

	always_comb begin
		min_a = '1;
		min_b = '1;
		min_c = '1;
		for (int m = 0; m < ALPHABET_SIZE; m++) begin
			if (set_a_q[m] && (col_q[m] < min_a)) begin
				min_a = col_q[m];
			end
			if (set_b_q[m] && (col_q[m] < min_b)) begin
				min_b = col_q[m];
			end
			if (set_c_q[m] && (col_q[m] < min_c)) begin
				min_c = col_q[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.min_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.min_en) begin
			min_a_s1 <= min_a;
			min_b_s1 <= min_b;
			min_c_s1 <= min_c;
			cand_s1  <= cnt_q;
		end
	end

	always_comb begin
		sum = ACC_W'(min_a_s1) + ACC_W'(min_b_s1)
			+ (three_q ? ACC_W'(min_c_s1) : ACC_W'(0));
		sat = (sum > ACC_W'(asmc_pkg::SUM_MAX)) ? asmc_pkg::SUM_MAX
			: sum[asmc_pkg::SUM_W-1:0];
		cand_bit = asmc_pkg::SET_W'(1) << cand_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if ((cand_s1 == '0) || (sat < best_q)) begin
				best_q   <= sat;
				median_q <= cand_bit;
			end else if (sat == best_q) begin
				median_q <= median_q | cand_bit;
			end
		end
	end

	assign best   = best_q;
	assign median = median_q;

endmodule
`default_nettype wire

@@ design/ambiguity_set_median_cost_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Ambiguity set median cost core
// Cost table loads and median queries over two or three ambiguity sets.
// ----------------------------------------------------------------------------
// Query channel (query_valid / query_stall) carries one item per transfer:
// func = 0 writes cost_table[row_symbol][col_symbol], func = 1 asks for the
// median over amb_first, amb_second and, with three_way, amb_third.
// Result channel (result_valid / result_stall) returns one item per query
// and none per write.
// A write completes in the fetch step. A query runs the fetch step, then the
// loop step, where one table column is read and reduced per cycle, then the
// drain and load steps; a query with an empty set goes to the error step.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the sequencer holds in its load step until
// the register frees.
// Reset clears the sequencer, the column counter and the result valid flag;
// the cost table keeps no reset value and must be written before it is read.
// ----------------------------------------------------------------------------
module ambiguity_set_median_cost_core #(
	parameter int ALPHABET_SIZE = asmc_pkg::ALPHABET_SIZE_DEF,
	parameter int COST_WIDTH    = asmc_pkg::COST_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          query_valid,
	output logic                               query_stall,
	input  wire logic                          func,
	input  wire logic [asmc_pkg::SYM_W-1:0]    row_symbol,
	input  wire logic [asmc_pkg::SYM_W-1:0]    col_symbol,
	input  wire logic [asmc_pkg::ENTRY_W-1:0]  entry_cost,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_first,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_second,
	input  wire logic [asmc_pkg::SET_W-1:0]    amb_third,
	input  wire logic                          three_way,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [asmc_pkg::SUM_W-1:0]         min_cost,
	output logic [asmc_pkg::SET_W-1:0]         median_set,
	output logic                               empty_set_error
);

	asmc_pkg::ctl_t  ctl;
	asmc_pkg::stat_t stat;

	logic                       last;
	logic [asmc_pkg::SUM_W-1:0] best;
	logic [asmc_pkg::SET_W-1:0] median;
	logic                       ld;
	logic                       result_valid_q;
	logic [asmc_pkg::SUM_W-1:0] min_cost_q;
	logic [asmc_pkg::SET_W-1:0] median_set_q;
	logic                       err_q;

	assign query_stall = !ctl.accept;

	always_comb begin
		stat.acc = query_valid && !query_stall;
		stat.write = !func;
		stat.empty = !(|amb_first[ALPHABET_SIZE-1:0]) || !(|amb_second[ALPHABET_SIZE-1:0])
			|| (three_way && !(|amb_third[ALPHABET_SIZE-1:0]));
		stat.last = last;
		stat.out_free = !result_valid_q || !result_stall;
	end

	asmc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	asmc_dp #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COST_WIDTH    (COST_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.acc        (stat.acc),
		.func       (func),
		.row_symbol (row_symbol),
		.col_symbol (col_symbol),
		.entry_cost (entry_cost),
		.amb_first  (amb_first),
		.amb_second (amb_second),
		.amb_third  (amb_third),
		.three_way  (three_way),
		.last       (last),
		.best       (best),
		.median     (median)
	);

	assign ld = ctl.out_ld && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ld) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			min_cost_q   <= ctl.out_err ? '0 : best;
			median_set_q <= ctl.out_err ? '0 : median;
			err_q        <= ctl.out_err;
		end
	end

	assign result_valid    = result_valid_q;
	assign min_cost        = min_cost_q;
	assign median_set      = median_set_q;
	assign empty_set_error = err_q;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && err_q |-> (min_cost_q == '0) && (median_set_q == '0))
		else $error("error result carries nonzero cost or set");

	a_median_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !err_q |-> (median_set_q != '0)
			&& ((median_set_q >> ALPHABET_SIZE) == '0))
		else $error("median set empty or outside alphabet");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.acc && !stat.write && !stat.empty |=> query_stall)
		else $error("query transfer not followed by busy sequencer");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_ambiguity_set_median_cost_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for ambiguity_set_median_cost_core
// Fills the cost table, then runs directed and random table writes and median
// queries through the query channel under random idling on both sides and one
// long result hold-off. A local model predicts each median result, and every
// result transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_ambiguity_set_median_cost_core;

	localparam int SYM_W = asmc_pkg::SYM_W;
	localparam int SET_W = asmc_pkg::SET_W;
	localparam int ENTRY_W = asmc_pkg::ENTRY_W;
	localparam int SUM_W = asmc_pkg::SUM_W;
	localparam bit [SUM_W-1:0] SUM_MAX = asmc_pkg::SUM_MAX;
	localparam int ALPHA = asmc_pkg::ALPHABET_SIZE_DEF;
	localparam bit [ENTRY_W-1:0] COST_MASK =
		ENTRY_W'((64'd1 << asmc_pkg::COST_WIDTH_DEF) - 1);
	localparam bit [SET_W-1:0] ALPHA_BITS = SET_W'((1 << ALPHA) - 1);
	localparam bit FUNC_WRITE = 1'b0;
	localparam bit FUNC_QUERY = 1'b1;
	localparam int RAND_ITEMS = 1260;
	localparam int HOLD_CYCLES = 120;

	typedef struct {
		bit               func;
		bit [SYM_W-1:0]   row;
		bit [SYM_W-1:0]   col;
		bit [ENTRY_W-1:0] cost;
		bit [SET_W-1:0]   s1;
		bit [SET_W-1:0]   s2;
		bit [SET_W-1:0]   s3;
		bit               three;
		int               phase;
	} request_t;

	typedef struct packed {
		logic [SUM_W-1:0] cost;
		logic [SET_W-1:0] set;
		logic             err;
	} median_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               query_valid = 1'b0;
	logic               query_stall;
	logic               func = 1'b0;
	logic [SYM_W-1:0]   row_symbol = '0;
	logic [SYM_W-1:0]   col_symbol = '0;
	logic [ENTRY_W-1:0] entry_cost = '0;
	logic [SET_W-1:0]   amb_first = '0;
	logic [SET_W-1:0]   amb_second = '0;
	logic [SET_W-1:0]   amb_third = '0;
	logic               three_way = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [SUM_W-1:0]   min_cost;
	logic [SET_W-1:0]   median_set;
	logic               empty_set_error;

	ambiguity_set_median_cost_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.func(func),
		.row_symbol(row_symbol),
		.col_symbol(col_symbol),
		.entry_cost(entry_cost),
		.amb_first(amb_first),
		.amb_second(amb_second),
		.amb_third(amb_third),
		.three_way(three_way),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.min_cost(min_cost),
		.median_set(median_set),
		.empty_set_error(empty_set_error)
	);

	int unsigned tx_idle_pct [3] = '{28, 59, 0};
	int unsigned rx_idle_pct [3] = '{59, 28, 0};

	request_t request_q [$];
	median_t  median_q [$];
	request_t offer;
	bit [ENTRY_W-1:0] cost_model [0:ALPHA-1][0:ALPHA-1];

	int cur_phase = 0;
	int accepted_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int n_writes = 0;
	int n_errors = 0;
	int n_ties = 0;
	int n_checked = 0;
	int n_fail = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit [ENTRY_W-1:0] column_floor(input bit [SET_W-1:0] set, input int cand);
		bit [ENTRY_W-1:0] best;
		bit found;
		int m;
		best = '0;
		found = 1'b0;
		for (m = 0; m < ALPHA; m++) begin
			if (set[m] && (!found || cost_model[m][cand] < best)) begin
				best = cost_model[m][cand];
				found = 1'b1;
			end
		end
		return best;
	endfunction

	task automatic apply_request(input request_t rq);
		median_t m;
		bit [SUM_W+1:0] sum;
		bit [SET_W-1:0] s1, s2, s3;
		bit have;
		int cand;
		m = '0;
		if (rq.func == FUNC_WRITE) begin
			n_writes++;
			if (rq.row < ALPHA && rq.col < ALPHA)
				cost_model[rq.row][rq.col] = rq.cost & COST_MASK;
			return;
		end
		s1 = rq.s1 & ALPHA_BITS;
		s2 = rq.s2 & ALPHA_BITS;
		s3 = rq.s3 & ALPHA_BITS;
		if (s1 == '0 || s2 == '0 || (rq.three && s3 == '0)) begin
			m.err = 1'b1;
			n_errors++;
		end else begin
			have = 1'b0;
			for (cand = 0; cand < ALPHA; cand++) begin
				sum = column_floor(s1, cand) + column_floor(s2, cand);
				if (rq.three)
					sum += column_floor(s3, cand);
				if (sum > SUM_MAX)
					sum = SUM_MAX;
				if (!have || sum[SUM_W-1:0] < m.cost) begin
					m.cost = sum[SUM_W-1:0];
					m.set = SET_W'(1 << cand);
					have = 1'b1;
				end else if (sum[SUM_W-1:0] == m.cost) begin
					m.set[cand] = 1'b1;
				end
			end
			if ($countones(m.set) > 1)
				n_ties++;
		end
		median_q.push_back(m);
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s got %0d want %0d", $time, what, got, want);
		n_fail++;
	endtask

	task automatic check_result();
		median_t want;
		if (median_q.size() == 0) begin
			flag_mismatch("unrequested result, min_cost", min_cost, 0);
			return;
		end
		want = median_q.pop_front();
		n_checked++;
		if (min_cost !== want.cost)
			flag_mismatch("min_cost", min_cost, want.cost);
		if (median_set !== want.set)
			flag_mismatch("median_set", median_set, want.set);
		if (empty_set_error !== want.err)
			flag_mismatch("empty_set_error", empty_set_error, want.err);
	endtask

	task automatic queue_write(input int r, input int c, input bit [ENTRY_W-1:0] cost,
			input int phase);
		request_t rq;
		rq.func = FUNC_WRITE;
		rq.row = SYM_W'(r);
		rq.col = SYM_W'(c);
		rq.cost = cost;
		rq.s1 = SET_W'($urandom);
		rq.s2 = SET_W'($urandom);
		rq.s3 = SET_W'($urandom);
		rq.three = 1'($urandom);
		rq.phase = phase;
		request_q.push_back(rq);
	endtask

	task automatic queue_median(input bit [SET_W-1:0] s1, input bit [SET_W-1:0] s2,
			input bit [SET_W-1:0] s3, input bit three, input int phase);
		request_t rq;
		rq.func = FUNC_QUERY;
		rq.row = SYM_W'($urandom);
		rq.col = SYM_W'($urandom);
		rq.cost = ENTRY_W'($urandom);
		rq.s1 = s1;
		rq.s2 = s2;
		rq.s3 = s3;
		rq.three = three;
		rq.phase = phase;
		request_q.push_back(rq);
	endtask

	function automatic bit [SET_W-1:0] random_set();
		bit [SET_W-1:0] v;
		v = SET_W'($urandom);
		case ($urandom_range(19))
			0, 1: v = v & ~ALPHA_BITS;
			2, 3, 4, 5, 6: v = (v & ~ALPHA_BITS) | SET_W'(1 << $urandom_range(ALPHA - 1));
			default: ;
		endcase
		return v;
	endfunction

	// driver: hold a stalled transfer, otherwise offer the next item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid <= 1'b0;
			func <= FUNC_WRITE;
			row_symbol <= '0;
			col_symbol <= '0;
			entry_cost <= '0;
			amb_first <= '0;
			amb_second <= '0;
			amb_third <= '0;
			three_way <= 1'b0;
		end else begin
			if (query_valid && !query_stall) begin
				apply_request(offer);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!query_valid || !query_stall) begin
				if (request_q.size() != 0 &&
						$urandom_range(99) >= tx_idle_pct[request_q[0].phase]) begin
					offer = request_q.pop_front();
					cur_phase <= offer.phase;
					func <= offer.func;
					row_symbol <= offer.row;
					col_symbol <= offer.col;
					entry_cost <= offer.cost;
					amb_first <= offer.s1;
					amb_second <= offer.s2;
					amb_third <= offer.s3;
					three_way <= offer.three;
					query_valid <= 1'b1;
				end else begin
					query_valid <= 1'b0;
				end
			end
		end
	end

	// long result hold-off once the sender stops idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && cur_phase == 2) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// monitor: check each result transfer, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			result_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct[cur_phase]);
		end
	end

	initial begin
		int r, c, i, phase;
		bit [ENTRY_W-1:0] cost;

		// fill the whole table first
		for (r = 0; r < ALPHA; r++) begin
			for (c = 0; c < ALPHA; c++) begin
				if (r == c)
					cost = '0;
				else if (r == 2 && c == 3)
					cost = '1;
				else if (r == 3 && c == 1)
					cost = 16'h8000;
				else
					cost = ENTRY_W'((r * 37 + c * 11) % 23 + 1);
				queue_write(r, c, cost, 0);
			end
		end
		queue_median(8'h1F, 8'h1F, 8'h00, 1'b0, 0);
		queue_median(8'h03, 8'h0C, 8'h10, 1'b1, 0);
		queue_median(8'hE1, 8'hFF, 8'h82, 1'b1, 0);
		queue_median(8'hE0, 8'h01, 8'h01, 1'b0, 0);
		queue_median(8'h01, 8'h00, 8'h01, 1'b0, 0);
		queue_median(8'h01, 8'h02, 8'h00, 1'b1, 0);
		queue_median(8'h01, 8'h02, 8'h00, 1'b0, 0);
		queue_median(8'h04, 8'h08, 8'hFF, 1'b0, 0);
		// writes outside the alphabet must leave the table alone
		queue_write(7, 0, 16'h1234, 0);
		queue_write(0, 5, 16'h1234, 0);
		queue_write(5, 7, 16'hFFFF, 0);
		queue_median(8'h01, 8'h01, 8'h01, 1'b1, 0);
		// row of maximum costs: largest sum, every candidate ties
		for (c = 0; c < ALPHA; c++)
			queue_write(4, c, 16'hFFFF, 0);
		queue_median(8'h10, 8'h10, 8'h10, 1'b1, 0);

		for (i = 0; i < RAND_ITEMS; i++) begin
			phase = i * 3 / RAND_ITEMS;
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(3) == 0) begin
					r = $urandom_range(7);
					c = $urandom_range(7);
				end else begin
					r = $urandom_range(ALPHA - 1);
					c = $urandom_range(ALPHA - 1);
				end
				if ($urandom_range(1) == 0)
					cost = ENTRY_W'($urandom_range(3));
				else
					cost = ENTRY_W'($urandom);
				queue_write(r, c, cost, phase);
			end else begin
				queue_median(random_set(), random_set(), random_set(), 1'($urandom), phase);
			end
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || query_valid || median_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d transfers in (%0d table writes), %0d results checked", accepted_cnt,
			n_writes, n_checked);
		$display("%0d empty-set errors, %0d tied medians, one %0d-cycle result hold-off",
			n_errors, n_ties, HOLD_CYCLES);
		if (n_fail == 0)
			$display("ambiguity_set_median_cost_core: match");
		else
			$display("ambiguity_set_median_cost_core: mismatch");
		$finish;
	end

	initial begin
		#3ms;
		$display("ambiguity_set_median_cost_core: mismatch");
		$finish;
	end

endmodule
